// ----- hdl/iframe_assembler_with_byte_stuffing_macros.svh -----
// Assertion macros for the information frame assembler.
`ifndef IFRAME_ASSEMBLER_WITH_BYTE_STUFFING_MACROS_SVH
`define IFRAME_ASSEMBLER_WITH_BYTE_STUFFING_MACROS_SVH
`ifndef SYNTHESIS
// Check cons in the same cycle as ante.
`define IAB_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Check cons in the cycle after ante.
`define IAB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define IAB_ASSERT_SAME(label, ante, cons)
`define IAB_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- hdl/iab_pkg.sv -----
// Package: types, constants and helpers of the information frame assembler.
`default_nettype none
package iab_pkg;

  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] ESC_FLAG  = 8'h5E;
  localparam logic [7:0] ESC_ESC   = 8'h5D;

  localparam int DEF_PAYLOAD_LIMIT = 4096;
  localparam int DEF_QUEUE_DEPTH   = 4;
  localparam int CNT_W             = 13;

  // Register indexes.
  localparam logic [1:0] REG_ROLE    = 2'd0;
  localparam logic [1:0] REG_ADDR_TX = 2'd1;
  localparam logic [1:0] REG_ADDR_RX = 2'd2;
  localparam logic [1:0] REG_MAX_PL  = 2'd3;

  localparam logic [7:0]       RST_ADDR_TX = 8'd3;
  localparam logic [7:0]       RST_ADDR_RX = 8'd1;
  localparam logic [CNT_W-1:0] RST_MAX_PL  = 13'd1024;

  // Output segments of one item, in line order.
  localparam logic [2:0] SEG_OPEN  = 3'd0;
  localparam logic [2:0] SEG_ADDR  = 3'd1;
  localparam logic [2:0] SEG_CTL   = 3'd2;
  localparam logic [2:0] SEG_BCC1  = 3'd3;
  localparam logic [2:0] SEG_DATA  = 3'd4;
  localparam logic [2:0] SEG_DROP  = 3'd5;
  localparam logic [2:0] SEG_BCC2  = 3'd6;
  localparam logic [2:0] SEG_CLOSE = 3'd7;

  // Segments that get byte stuffing in an information frame.
  localparam logic [7:0] STUFF_SEGS = 8'b0101_1110;
  // Segment set of a supervisory frame.
  localparam logic [7:0] SUP_SEGS   = 8'b1000_1111;

  typedef struct packed {
    logic             role;
    logic [7:0]       addr_tx;
    logic [7:0]       addr_rx;
    logic [CNT_W-1:0] max_payload;
  } iab_cfg_t;

  typedef struct packed {
    logic [7:0] mask;
    logic       stuff;
    logic       ov;
    logic [7:0] addr;
    logic [7:0] ctl;
    logic [7:0] dat;
    logic [7:0] bcc;
  } iab_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } iab_qstat_t;

  // Encode a one-hot segment mask.
  function automatic logic [2:0] seg_index(input logic [7:0] oh);
    logic [2:0] idx;
    idx = '0;
    for (int i = 0; i < 8; i++) begin
      if (oh[i]) begin
        idx = idx | 3'(i);
      end
    end
    return idx;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/iab_if.sv -----
// Channel interfaces: input items and line bytes.
`default_nettype none
interface iab_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] control;
  logic [7:0] data;
  logic       last;
  modport source (output valid, output cmd, output control, output data, output last,
                  input ready);
  modport sink (input valid, input cmd, input control, input data, input last,
                output ready);
endinterface

interface iab_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       frame_end;
  logic       overflow;
  modport source (output valid, output out_byte, output run_last, output frame_end,
                  output overflow, input ready);
  modport sink (input valid, input out_byte, input run_last, input frame_end,
                input overflow, output ready);
endinterface
`default_nettype wire

// ----- hdl/iab_regs.sv -----
// APB configuration registers.
`default_nettype none
module iab_regs
  import iab_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output iab_cfg_t         cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.role        <= 1'b0;
      cfg.addr_tx     <= RST_ADDR_TX;
      cfg.addr_rx     <= RST_ADDR_RX;
      cfg.max_payload <= RST_MAX_PL;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_ROLE:    cfg.role        <= pwdata[0];
        REG_ADDR_TX: cfg.addr_tx     <= pwdata[7:0];
        REG_ADDR_RX: cfg.addr_rx     <= pwdata[7:0];
        REG_MAX_PL:  cfg.max_payload <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ROLE:    prdata = {31'd0, cfg.role};
      REG_ADDR_TX: prdata = {24'd0, cfg.addr_tx};
      REG_ADDR_RX: prdata = {24'd0, cfg.addr_rx};
      REG_MAX_PL:  prdata = {{(32-CNT_W){1'b0}}, cfg.max_payload};
      default:     prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ----- hdl/iab_front.sv -----
// Front end: accept items, track frame state, classify into segment records.
`default_nettype none
module iab_front
  import iab_pkg::*;
#(
  parameter int PAYLOAD_LIMIT = DEF_PAYLOAD_LIMIT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  iab_in_if.sink          in_ch,
  input  wire iab_cfg_t   cfg,
  input  wire iab_qstat_t qstat,
  output logic            push,
  output iab_rec_t        rec,
  output logic            in_frame
);

  // Count register saturates at its width; a larger limit never binds.
  localparam int CNT_MAX = (1 << CNT_W) - 1;
  localparam int CAP     = (PAYLOAD_LIMIT > CNT_MAX) ? CNT_MAX : PAYLOAD_LIMIT;
  localparam logic [CNT_W-1:0] CAP_V = CAP[CNT_W-1:0];

  logic [7:0]       payload_xor;
  logic [CNT_W-1:0] payload_count;

  logic [CNT_W-1:0] lim;
  logic             opn;
  logic [7:0]       base_xor;
  logic [CNT_W-1:0] base_cnt;
  logic             take;
  logic [7:0]       new_xor;
  logic [7:0]       addr;

  assign in_ch.ready = !qstat.full;
  assign push        = in_ch.valid && in_ch.ready;

  always_comb begin
    lim = (cfg.max_payload > CAP_V) ? CAP_V : cfg.max_payload;
    if (lim == '0) begin
      lim = CNT_W'(1);
    end
    addr     = cfg.role ? cfg.addr_rx : cfg.addr_tx;
    opn      = !in_frame;
    base_xor = opn ? 8'd0 : payload_xor;
    base_cnt = opn ? '0 : payload_count;
    take     = base_cnt < lim;
    new_xor  = take ? (base_xor ^ in_ch.data) : base_xor;

    rec.addr  = addr;
    rec.ctl   = in_ch.control;
    rec.dat   = in_ch.data;
    rec.bcc   = new_xor;
    if (in_ch.cmd) begin
      rec.mask  = SUP_SEGS;
      rec.stuff = 1'b0;
      rec.ov    = 1'b0;
    end else begin
      rec.mask  = '0;
      rec.mask[SEG_OPEN]  = opn;
      rec.mask[SEG_ADDR]  = opn;
      rec.mask[SEG_CTL]   = opn;
      rec.mask[SEG_BCC1]  = opn;
      rec.mask[SEG_DATA]  = take;
      rec.mask[SEG_DROP]  = !take && !in_ch.last;
      rec.mask[SEG_BCC2]  = in_ch.last;
      rec.mask[SEG_CLOSE] = in_ch.last;
      rec.stuff = 1'b1;
      rec.ov    = !take;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame      <= 1'b0;
      payload_xor   <= '0;
      payload_count <= '0;
    end else if (push) begin
      if (in_ch.cmd || in_ch.last) begin
        in_frame      <= 1'b0;
        payload_xor   <= '0;
        payload_count <= '0;
      end else begin
        in_frame      <= 1'b1;
        payload_xor   <= new_xor;
        payload_count <= base_cnt + CNT_W'(take);
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/iab_queue.sv -----
// Short record queue between front and back.
`default_nettype none
module iab_queue
  import iab_pkg::*;
#(
  parameter int DEPTH = DEF_QUEUE_DEPTH
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire iab_rec_t wr_rec,
  input  wire logic     pop,
  output iab_rec_t      rd_rec,
  output iab_qstat_t    qstat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  iab_rec_t      slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] fill;

  assign qstat.full  = (fill == FULL_CNT);
  assign qstat.empty = (fill == '0);
  assign rd_rec      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   fill <= fill + CW'(1);
        2'b01:   fill <= fill - CW'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hdl/iab_back.sv -----
// Back end: walk segments of a record, stuff bytes, drive the output register.
`default_nettype none
module iab_back
  import iab_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire iab_qstat_t qstat,
  input  wire iab_rec_t   rd_rec,
  output logic            pop,
  iab_out_if.source       out_ch
);

  iab_rec_t   cur;
  logic       cur_valid;
  logic [7:0] pend;
  logic       esc_phase;
  logic       ovld;

  logic [7:0] cur_oh;
  logic [7:0] rest;
  logic [2:0] seg;
  logic [7:0] raw;
  logic       needs_esc;
  logic       byte_done;
  logic       last_byte;
  logic       advance;
  logic [7:0] byte_val;

  always_comb begin
    cur_oh = pend & (~pend + 8'd1);
    rest   = pend & ~cur_oh;
    seg    = seg_index(cur_oh);
    case (seg)
      SEG_OPEN:  raw = FLAG_BYTE;
      SEG_ADDR:  raw = cur.addr;
      SEG_CTL:   raw = cur.ctl;
      SEG_BCC1:  raw = cur.addr ^ cur.ctl;
      SEG_DATA:  raw = cur.dat;
      SEG_DROP:  raw = 8'd0;
      SEG_BCC2:  raw = cur.bcc;
      SEG_CLOSE: raw = FLAG_BYTE;
      default:   raw = 8'd0;
    endcase
    needs_esc = cur.stuff && STUFF_SEGS[seg] && (raw == FLAG_BYTE || raw == ESC_BYTE);
    byte_done = !needs_esc || esc_phase;
    last_byte = byte_done && (rest == '0);
    if (needs_esc && !esc_phase) begin
      byte_val = ESC_BYTE;
    end else if (needs_esc) begin
      byte_val = (raw == FLAG_BYTE) ? ESC_FLAG : ESC_ESC;
    end else begin
      byte_val = raw;
    end
    advance = cur_valid && (!ovld || out_ch.ready);
    pop     = !qstat.empty && (!cur_valid || (advance && last_byte));
  end

  assign out_ch.valid = ovld;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      esc_phase <= 1'b0;
      ovld      <= 1'b0;
    end else begin
      if (pop) begin
        cur_valid <= 1'b1;
        esc_phase <= 1'b0;
      end else if (advance) begin
        if (byte_done) begin
          esc_phase <= 1'b0;
          if (rest == '0) begin
            cur_valid <= 1'b0;
          end
        end else begin
          esc_phase <= 1'b1;
        end
      end
      if (advance) begin
        ovld <= 1'b1;
      end else if (out_ch.ready) begin
        ovld <= 1'b0;
      end
    end
  end

  // Record and segment set; cur_valid qualifies them.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur  <= rd_rec;
      pend <= rd_rec.mask;
    end else if (advance && byte_done) begin
      pend <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_ch.out_byte  <= byte_val;
      out_ch.run_last  <= last_byte;
      out_ch.frame_end <= (seg == SEG_CLOSE);
      out_ch.overflow  <= cur.ov;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/iframe_assembler_with_byte_stuffing.sv -----
// Path: queue slot, back-end record register, output register.
// Throughput: one item per cycle into the queue while it has room, one line byte per
//   cycle out while the sink is ready; a stuffed byte goes out as an escape pair, an
//   opening byte adds flag, address, control and check, a last byte check and flag.
// Reset (rst, synchronous): registers return to defaults, no frame open, queue
//   and output register empty.
`default_nettype none
`include "iframe_assembler_with_byte_stuffing_macros.svh"
module iframe_assembler_with_byte_stuffing
  import iab_pkg::*;
#(
  parameter int PAYLOAD_LIMIT = DEF_PAYLOAD_LIMIT,
  parameter int QUEUE_DEPTH   = DEF_QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  iab_in_if.sink           in_ch,
  iab_out_if.source        out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  iab_cfg_t   cfg;
  iab_qstat_t qstat;
  iab_rec_t   wr_rec;
  iab_rec_t   rd_rec;
  logic       push;
  logic       pop;
  logic       in_frame;

  // Register file: role, two addresses, payload limit.
  iab_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Front: take each input transfer while the queue has room, update the
  // running frame state (open flag, payload XOR, payload count) and turn the
  // item into a record that lists which segments to send.
  iab_front #(
    .PAYLOAD_LIMIT (PAYLOAD_LIMIT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .cfg      (cfg),
    .qstat    (qstat),
    .push     (push),
    .rec      (wr_rec),
    .in_frame (in_frame)
  );

  // Queue: lets the front keep accepting while the back drains long items.
  iab_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_rec (wr_rec),
    .pop    (pop),
    .rd_rec (rd_rec),
    .qstat  (qstat)
  );

  // Back: walk the segments of one record, insert escapes, and hold each byte
  // in the output register until the sink takes it.
  iab_back u_back (
    .clk    (clk),
    .rst    (rst),
    .qstat  (qstat),
    .rd_rec (rd_rec),
    .pop    (pop),
    .out_ch (out_ch)
  );

  // Never write into a full queue.
  `IAB_ASSERT_SAME(a_no_push_full, qstat.full, !push)
  // A supervisory item or a last payload byte closes the frame.
  `IAB_ASSERT_NEXT(a_frame_closed, push && (in_ch.cmd || in_ch.last), !in_frame)
  // A closing flag is always the final byte of its item.
  `IAB_ASSERT_SAME(a_close_final, out_ch.valid && out_ch.frame_end, out_ch.run_last)
  // Pop only with data present.
  `IAB_ASSERT_SAME(a_pop_nonempty, pop, !qstat.empty)

endmodule
`default_nettype wire

// ----- dv/iframe_assembler_with_byte_stuffing_tb.sv -----
// Testbench for the information frame assembler: directed and random items checked by a predictor.
`timescale 1ns / 100ps
module iframe_assembler_with_byte_stuffing_tb
  import iab_pkg::*;
();

  // Item command codes.
  localparam logic CMD_PAYLOAD = 1'b0;
  localparam logic CMD_SUPER   = 1'b1;

  localparam int MAX_SHOWN    = 10;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 52;
  localparam int SETTLE_TICKS = 10;

  typedef struct packed {
    logic       cmd;
    logic [7:0] control;
    logic [7:0] data;
    logic       last;
  } frame_item_t;

  typedef struct packed {
    logic [7:0] octet;
    logic       run_last;
    logic       frame_end;
    logic       overflow;
  } line_octet_t;

  // One row of the directed plan: a register write or an item. Where gold_n is
  // nonzero the row carries its line bytes typed in, first byte at the top.
  typedef struct {
    bit          is_cfg;
    logic [1:0]  reg_idx;
    logic [31:0] reg_val;
    frame_item_t item;
    int          gold_n;
    logic [63:0] gold;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  iab_in_if  in_ch ();
  iab_out_if out_ch ();

  iframe_assembler_with_byte_stuffing u_top (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Framer model: register copy, open-frame state and the line bytes still owed.
  iab_cfg_t          cfg_model;
  logic              fr_open;
  logic [7:0]        fr_xor;
  logic [CNT_W-1:0]  fr_count;
  line_octet_t       line_q[$];

  plan_row_t plan[$];

  int src_idle_pct;
  int snk_stall_pct;
  int fail_cnt;
  int items_sent;
  int super_sent;
  int octets_seen;
  int ov_seen;
  int cfg_writes;

  // ---------------------------------------------------------------------------
  // Framer model
  // ---------------------------------------------------------------------------

  function automatic void put_octet(input logic [7:0] b, input logic fe, input logic ov);
    line_octet_t o;
    o.octet     = b;
    o.run_last  = 1'b0;
    o.frame_end = fe;
    o.overflow  = ov;
    line_q.push_back(o);
  endfunction

  // Escape a flag or an escape byte into two line bytes.
  function automatic void put_stuffed(input logic [7:0] b, input logic ov);
    if (b == FLAG_BYTE) begin
      put_octet(ESC_BYTE, 1'b0, ov);
      put_octet(ESC_FLAG, 1'b0, ov);
    end else if (b == ESC_BYTE) begin
      put_octet(ESC_BYTE, 1'b0, ov);
      put_octet(ESC_ESC, 1'b0, ov);
    end else begin
      put_octet(b, 1'b0, ov);
    end
  endfunction

  // Tag the newest owed byte as the end of the run for its item.
  function automatic void mark_run_end();
    line_octet_t tail;
    tail = line_q[$];
    tail.run_last = 1'b1;
    line_q[line_q.size() - 1] = tail;
  endfunction

  // Work out the line bytes of one accepted item and advance the frame state.
  function automatic void frame_item(input frame_item_t it);
    logic [7:0] addr;
    logic       ov;
    int         cap;
    addr = cfg_model.role ? cfg_model.addr_rx : cfg_model.addr_tx;
    ov   = 1'b0;
    cap  = cfg_model.max_payload;
    if (cap > DEF_PAYLOAD_LIMIT) cap = DEF_PAYLOAD_LIMIT;
    if (cap < 1) cap = 1;
    if (it.cmd == CMD_SUPER) begin
      // Abandon any open frame; the S frame's opening flag ends it on the line.
      fr_open  = 1'b0;
      fr_xor   = '0;
      fr_count = '0;
      put_octet(FLAG_BYTE, 1'b0, 1'b0);
      put_octet(addr, 1'b0, 1'b0);
      put_octet(it.control, 1'b0, 1'b0);
      put_octet(addr ^ it.control, 1'b0, 1'b0);
      put_octet(FLAG_BYTE, 1'b1, 1'b0);
    end else begin
      if (!fr_open) begin
        fr_open  = 1'b1;
        fr_xor   = '0;
        fr_count = '0;
        put_octet(FLAG_BYTE, 1'b0, 1'b0);
        put_stuffed(addr, 1'b0);
        put_stuffed(it.control, 1'b0);
        put_stuffed(addr ^ it.control, 1'b0);
      end
      if (fr_count < cap) begin
        fr_xor   = fr_xor ^ it.data;
        fr_count = fr_count + 1'b1;
        put_stuffed(it.data, 1'b0);
      end else begin
        ov = 1'b1;
        if (!it.last) put_octet(8'h00, 1'b0, 1'b1);
      end
      if (it.last) begin
        put_stuffed(fr_xor, ov);
        put_octet(FLAG_BYTE, 1'b1, ov);
        fr_open  = 1'b0;
        fr_xor   = '0;
        fr_count = '0;
      end
    end
    mark_run_end();
  endfunction

  // Bias toward the two bytes that need escaping.
  function automatic logic [7:0] pick_octet();
    case ($urandom_range(7))
      0:       return FLAG_BYTE;
      1:       return ESC_BYTE;
      default: return 8'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Register port
  // ---------------------------------------------------------------------------

  task automatic read_check(input logic [1:0] idx, input logic [31:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      fail_cnt++;
      if (fail_cnt <= MAX_SHOWN)
        $display("register %0d: expected %h, read %h", idx, want, prdata);
    end
  endtask

  // Write one register, mirror it in the model, read it back.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    logic [31:0] kept;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_ROLE: begin
        cfg_model.role = val[0];
        kept = {31'b0, val[0]};
      end
      REG_ADDR_TX: begin
        cfg_model.addr_tx = val[7:0];
        kept = {24'b0, val[7:0]};
      end
      REG_ADDR_RX: begin
        cfg_model.addr_rx = val[7:0];
        kept = {24'b0, val[7:0]};
      end
      default: begin
        cfg_model.max_payload = val[CNT_W-1:0];
        kept = {{(32 - CNT_W){1'b0}}, val[CNT_W-1:0]};
      end
    endcase
    cfg_writes++;
    read_check(idx, kept);
  endtask

  // ---------------------------------------------------------------------------
  // Item sender
  // ---------------------------------------------------------------------------

  // Offer one item, hold it until the transfer, then predict its line bytes.
  // Leave valid high on return; the next call or a drain lowers it.
  task automatic send_item(input frame_item_t it, input int gold_n, input logic [63:0] gold);
    int before_n;
    // Park the register port; it is only ever used while the framer is idle.
    psel    <= 1'b0;
    penable <= 1'b0;
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.cmd     <= it.cmd;
    in_ch.control <= it.control;
    in_ch.data    <= it.data;
    in_ch.last    <= it.last;
    do @(posedge clk); while (!in_ch.ready);
    before_n = line_q.size();
    frame_item(it);
    if (gold_n > 0) begin
      // Swap in the typed-in bytes; the model still advances its frame state.
      while (line_q.size() > before_n) void'(line_q.pop_back());
      for (int k = 0; k < gold_n; k++)
        put_octet(gold[8 * (gold_n - 1 - k) +: 8], k == gold_n - 1, 1'b0);
      mark_run_end();
    end
    items_sent++;
    if (it.cmd == CMD_SUPER) super_sent++;
  endtask

  // Stop offering and hold until every owed line byte has come out.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (line_q.size() != 0) @(posedge clk);
  endtask

  task automatic add_item(input logic cmd, input logic [7:0] ctl, input logic [7:0] dat,
                          input logic lst, input int gold_n, input logic [63:0] gold);
    plan_row_t r;
    r.is_cfg  = 1'b0;
    r.reg_idx = '0;
    r.reg_val = '0;
    r.item    = '{cmd: cmd, control: ctl, data: dat, last: lst};
    r.gold_n  = gold_n;
    r.gold    = gold;
    plan.push_back(r);
  endtask

  task automatic add_cfg(input logic [1:0] idx, input logic [31:0] val);
    plan_row_t r;
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    r.item    = '0;
    r.gold_n  = 0;
    r.gold    = '0;
    plan.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // Line byte checker
  // ---------------------------------------------------------------------------

  line_octet_t seen_octet;
  line_octet_t want_octet;

  // Compare each line byte transfer with the oldest owed byte; stall at random.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        seen_octet = '{octet: out_ch.out_byte, run_last: out_ch.run_last,
                       frame_end: out_ch.frame_end, overflow: out_ch.overflow};
        if (line_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= MAX_SHOWN)
            $display("line byte %0d: none owed, got byte %h run_last %b frame_end %b overflow %b",
                     octets_seen, seen_octet.octet, seen_octet.run_last,
                     seen_octet.frame_end, seen_octet.overflow);
        end else begin
          want_octet = line_q.pop_front();
          if (seen_octet !== want_octet) begin
            fail_cnt++;
            if (fail_cnt <= MAX_SHOWN) begin
              $display("line byte %0d: expected byte %h run_last %b frame_end %b overflow %b",
                       octets_seen, want_octet.octet, want_octet.run_last,
                       want_octet.frame_end, want_octet.overflow);
              $display("line byte %0d: got byte %h run_last %b frame_end %b overflow %b",
                       octets_seen, seen_octet.octet, seen_octet.run_last,
                       seen_octet.frame_end, seen_octet.overflow);
            end
          end
        end
        octets_seen++;
        if (seen_octet.overflow) ov_seen++;
      end
      out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    int          base;
    int          len;
    logic [31:0] junk;
    logic [12:0] cap_val;
    frame_item_t it;

    rst           = 1'b1;
    in_ch.valid   = 1'b0;
    in_ch.cmd     = CMD_PAYLOAD;
    in_ch.control = '0;
    in_ch.data    = '0;
    in_ch.last    = 1'b0;
    out_ch.ready  = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    fail_cnt      = 0;
    items_sent    = 0;
    super_sent    = 0;
    octets_seen   = 0;
    ov_seen       = 0;
    cfg_writes    = 0;
    cfg_model     = '{role: 1'b0, addr_tx: RST_ADDR_TX, addr_rx: RST_ADDR_RX,
                      max_payload: RST_MAX_PL};
    fr_open       = 1'b0;
    fr_xor        = '0;
    fr_count      = '0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Registers must read back their defaults after reset.
    read_check(REG_ROLE, 32'd0);
    read_check(REG_ADDR_TX, {24'b0, RST_ADDR_TX});
    read_check(REG_ADDR_RX, {24'b0, RST_ADDR_RX});
    read_check(REG_MAX_PL, {19'b0, RST_MAX_PL});

    // Directed plan. Defaults: transmitter role, address 03, limit 1024.
    // Supervisory frames are never stuffed; last is ignored on them.
    add_item(CMD_SUPER,   8'h00, 8'h00, 1'b0, 5, 64'h7E_03_00_03_7E);
    add_item(CMD_SUPER,   8'hFF, 8'hFF, 1'b1, 5, 64'h7E_03_FF_FC_7E);
    // One-byte frame: the check byte equals the byte itself.
    add_item(CMD_PAYLOAD, 8'h00, 8'h11, 1'b1, 7, 64'h7E_03_00_03_11_11_7E);
    // Control, check byte one, data and check byte two all need escaping.
    add_item(CMD_PAYLOAD, 8'h7E, 8'h7E, 1'b1, 0, '0);
    // Multi-byte frame; control on continuation bytes is ignored.
    add_item(CMD_PAYLOAD, 8'h80, 8'h7D, 1'b0, 0, '0);
    add_item(CMD_PAYLOAD, 8'hFF, 8'h00, 1'b0, 0, '0);
    add_item(CMD_PAYLOAD, 8'h00, 8'hFF, 1'b0, 0, '0);
    add_item(CMD_PAYLOAD, 8'h55, 8'h7E, 1'b1, 0, '0);
    // Supervisory command while a frame is open abandons it.
    add_item(CMD_PAYLOAD, 8'h01, 8'h55, 1'b0, 0, '0);
    add_item(CMD_SUPER,   8'h13, 8'h00, 1'b0, 0, '0);
    // Receiver role with an address that needs escaping, limit of one byte:
    // drop a middle byte, then drop the last one.
    add_cfg(REG_MAX_PL,  32'd1);
    add_cfg(REG_ROLE,    32'hFFFF_FFFF);
    add_cfg(REG_ADDR_RX, 32'h0000_007E);
    add_item(CMD_PAYLOAD, 8'h00, 8'hAA, 1'b0, 0, '0);
    add_item(CMD_PAYLOAD, 8'h00, 8'hBB, 1'b0, 0, '0);
    add_item(CMD_PAYLOAD, 8'h00, 8'hCC, 1'b1, 0, '0);
    add_item(CMD_SUPER,   8'h7D, 8'h00, 1'b0, 0, '0);
    // Limit register at zero still lets one byte through.
    add_cfg(REG_MAX_PL,  32'd0);
    add_cfg(REG_ADDR_TX, 32'hABCD_127D);
    add_cfg(REG_ROLE,    32'd0);
    add_item(CMD_PAYLOAD, 8'h7D, 8'h7D, 1'b0, 0, '0);
    add_item(CMD_PAYLOAD, 8'h7E, 8'h01, 1'b1, 0, '0);
    // Limit register at its top clamps to the build-time limit.
    add_cfg(REG_MAX_PL,  32'h0000_1FFF);
    add_cfg(REG_ADDR_TX, 32'd255);
    add_item(CMD_PAYLOAD, 8'h00, 8'h00, 1'b1, 0, '0);
    add_item(CMD_PAYLOAD, 8'hFF, 8'hFF, 1'b1, 0, '0);
    add_cfg(REG_ADDR_RX, 32'd0);
    add_item(CMD_PAYLOAD, 8'hFF, 8'h80, 1'b1, 0, '0);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_item(plan[i].item, plan[i].gold_n, plan[i].gold);
      end
    end

    // Random phases: new register settings each phase, then mostly
    // well-formed frames with random content. Some frames are cut short by a
    // supervisory command.
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      junk = $urandom;
      write_reg(REG_ROLE, {junk[31:1], 1'($urandom_range(1))});
      junk = $urandom;
      write_reg(REG_ADDR_TX, {junk[31:8], pick_octet()});
      junk = $urandom;
      write_reg(REG_ADDR_RX, {junk[31:8], pick_octet()});
      case ($urandom_range(9))
        0:       cap_val = 13'd0;
        1:       cap_val = 13'd1;
        2:       cap_val = 13'd2;
        3:       cap_val = 13'd1024;
        4:       cap_val = 13'd4096;
        5:       cap_val = 13'd8191;
        default: cap_val = 13'($urandom_range(3, 12));
      endcase
      junk = $urandom;
      write_reg(REG_MAX_PL, {junk[31:13], cap_val});

      case (ph % 4)
        0: begin
          src_idle_pct  = 0;
          snk_stall_pct = 0;
        end
        1: begin
          src_idle_pct  = 73;
          snk_stall_pct = 0;
        end
        2: begin
          src_idle_pct  = 0;
          snk_stall_pct = 73;
        end
        default: begin
          src_idle_pct  = 7;
          snk_stall_pct = 7;
        end
      endcase

      base = items_sent;
      while (items_sent - base < PHASE_ITEMS) begin
        if ($urandom_range(99) < 15) begin
          it = '{cmd: CMD_SUPER, control: pick_octet(), data: 8'($urandom),
                 last: 1'($urandom_range(1))};
          send_item(it, 0, '0);
        end else begin
          len = ($urandom_range(3) == 0) ? 1 : $urandom_range(2, 14);
          for (int k = 0; k < len; k++) begin
            if (k > 0 && $urandom_range(99) < 4) begin
              // Break the frame off with a supervisory command.
              it = '{cmd: CMD_SUPER, control: pick_octet(), data: 8'($urandom), last: 1'b0};
              send_item(it, 0, '0);
              break;
            end
            it = '{cmd: CMD_PAYLOAD, control: pick_octet(), data: pick_octet(),
                   last: (k == len - 1)};
            send_item(it, 0, '0);
          end
        end
      end
    end

    // Wait out the owed bytes, then idle to catch anything stray.
    drain();
    repeat (SETTLE_TICKS) @(posedge clk);

    $display("covered %0d items (%0d supervisory) over %0d register writes and %0d phases",
             items_sent, super_sent, cfg_writes, PHASES);
    $display("checked %0d line bytes, %0d of them flagged overflow, %0d failures",
             octets_seen, ov_seen, fail_cnt);
    if (fail_cnt == 0) begin
      $display("iframe_assembler_with_byte_stuffing_tb OK");
    end else begin
      $display("iframe_assembler_with_byte_stuffing_tb NOT OK");
    end
    $finish;
  end

  // Hard stop: far beyond the slowest correct run.
  initial begin
    #1_000_000;
    $display("timeout with %0d line bytes still owed", line_q.size());
    $display("iframe_assembler_with_byte_stuffing_tb NOT OK");
    $finish;
  end

endmodule
